>>> rtl/core/gtpu_tunnel_header_parser_assert.svh
// assertion macros shared by the gtp-u header parser rtl
// expects clk and arst_n in the scope of each use
`ifndef GTPU_TUNNEL_HEADER_PARSER_ASSERT_SVH
`define GTPU_TUNNEL_HEADER_PARSER_ASSERT_SVH

// same-cycle implication
`define GTPU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GTPU_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/gtpu_hp_pkg.sv
// types and constants of the gtp-u tunnel header parser
// no dependencies
package gtpu_hp_pkg;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  parse_status;
		logic [31:0] tunnel_id;
		logic [5:0]  flow_qos_id;
		logic [31:0] inner_source;
		logic [31:0] inner_destination;
		logic [15:0] inner_total_length;
	} out_item_t;

	// parse status codes
	localparam logic [2:0] ST_NOT_GTPU     = 3'd0;
	localparam logic [2:0] ST_GTP_TRUNC    = 3'd1;
	localparam logic [2:0] ST_INNER_TRUNC  = 3'd2;
	localparam logic [2:0] ST_INNER_NOT_V4 = 3'd3;
	localparam logic [2:0] ST_OK           = 3'd4;

	localparam logic [15:0] PORT_AT_RESET = 16'd2152;

	// fixed outer header positions and values
	localparam int POS_ETYPE_HI  = 12;
	localparam int POS_ETYPE_LO  = 13;
	localparam int POS_IP_START  = 14;
	localparam int POS_IP_PROTO  = 23;
	localparam int MIN_FRAME     = 34;
	localparam int UDP_HDR_BYTES = 8;

	localparam logic [7:0] ETYPE_HI     = 8'h08;
	localparam logic [7:0] ETYPE_LO     = 8'h00;
	localparam logic [7:0] IP_PROTO_UDP = 8'd17;
	localparam logic [3:0] IP_VERSION_4 = 4'h4;

	// gtp-u flags and extension codes
	localparam logic [7:0] OPT_FLAGS = 8'h07;
	localparam int         E_FLAG_BIT = 2;
	localparam logic [7:0] PSC_TYPE  = 8'h85;
	localparam logic [5:0] QFI_MASK  = 6'h3F;

endpackage

>>> rtl/core/gtpu_hp_parser.sv
// per-byte parse state and result formation of the gtp-u header parser
// depends on gtpu_hp_pkg
module gtpu_hp_parser import gtpu_hp_pkg::*; #(
	parameter int MAX_EXT_HEADERS = 4,
	parameter int MAX_FRAME_BYTES = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  in_item_t    item,
	input  logic [15:0] udp_port,
	output out_item_t   result
);

	localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
	localparam int AW = PW + 1;
	localparam int XW = $clog2(MAX_EXT_HEADERS + 1);
	localparam int EW = ((PW > 10) ? PW : 10) + 1;
	localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_FRAME_BYTES);
	localparam logic [XW-1:0] EXT_LIMIT = XW'(MAX_EXT_HEADERS);

	typedef enum logic [2:0] {
		PH_OUTER, PH_BASE, PH_OPT, PH_EXT, PH_INNER, PH_DONE
	} phase_t;

	phase_t        phase_q, phase_d, ph;
	logic [PW-1:0] pos_q, pos_d;
	logic [3:0]    ohw_q, ohw_d, ohw_eff;
	logic [7:0]    flags_q, flags_d;
	logic [31:0]   tid_q, tid_d, port_shift;
	logic [7:0]    pet_q, pet_d;
	logic [XW-1:0] walked_q, walked_d;
	logic [EW-1:0] eep_q, eep_d;
	logic [PW-1:0] iso_q, iso_d;
	logic [5:0]    qfi_q, qfi_d;
	logic [15:0]   len_q, len_d;
	logic [31:0]   src_q, src_d;
	logic [31:0]   dst_q, dst_d;
	logic          rej_q, rej_d;
	logic [3:0]    ver_q, ver_d;

	logic [7:0]    b;
	logic [PW-1:0] p, d, k;
	logic [AW-1:0] p_w, u_w, g_w, g_end;
	logic          live, go_inner;

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		ohw_d    = ohw_q;
		flags_d  = flags_q;
		tid_d    = tid_q;
		pet_d    = pet_q;
		walked_d = walked_q;
		eep_d    = eep_q;
		iso_d    = iso_q;
		qfi_d    = qfi_q;
		len_d    = len_q;
		src_d    = src_q;
		dst_d    = dst_q;
		rej_d    = rej_q;
		ver_d    = ver_q;

		b   = item.frame_byte;
		p   = pos_q;
		p_w = {1'b0, pos_q};
		ohw_eff = (p == PW'(POS_IP_START)) ? b[3:0] : ohw_q;
		u_w = AW'(POS_IP_START) + AW'({ohw_eff, 2'b00});
		g_w = u_w + AW'(UDP_HDR_BYTES);
		d   = p - g_w[PW-1:0];
		k   = d - iso_q;
		port_shift = {tid_q[23:0], b};
		live     = 1'b0;
		go_inner = 1'b0;
		ph       = phase_q;

		if (p < POS_LIMIT) begin
			pos_d = p + PW'(1);
			if (p == PW'(POS_ETYPE_HI) && b != ETYPE_HI) rej_d = 1'b1;
			if (p == PW'(POS_ETYPE_LO) && b != ETYPE_LO) rej_d = 1'b1;
			if (p == PW'(POS_IP_PROTO) && b != IP_PROTO_UDP) rej_d = 1'b1;
			if (p == PW'(POS_IP_START)) ohw_d = b[3:0];
			if (p >= PW'(POS_IP_START)) begin
				// udp ports pass through the teid register
				if (p_w >= u_w && p_w <= u_w + AW'(3)) begin
					tid_d = port_shift;
					if (p_w == u_w + AW'(3) && port_shift[31:16] != udp_port
							&& port_shift[15:0] != udp_port)
						rej_d = 1'b1;
				end
				live = 1'b1;
				if (phase_q == PH_OUTER) begin
					if (p_w == g_w) ph = PH_BASE;
					else live = 1'b0;
				end
			end
		end

		if (live) begin
			phase_d = ph;
			unique case (ph)
				PH_BASE: begin
					if (d == '0) flags_d = b;
					if (d >= PW'(4)) tid_d = {tid_q[23:0], b};
					if (d == PW'(7)) begin
						if ((flags_q & OPT_FLAGS) != 8'h00) phase_d = PH_OPT;
						else begin
							iso_d   = PW'(8);
							phase_d = PH_INNER;
						end
					end
				end
				PH_OPT: begin
					if (d == PW'(11)) begin
						iso_d = PW'(12);
						if (flags_q[E_FLAG_BIT] && b != 8'h00) begin
							pet_d    = b;
							walked_d = '0;
							phase_d  = PH_EXT;
						end else begin
							phase_d = PH_INNER;
						end
					end
				end
				PH_EXT: begin
					if (d == iso_q) begin
						// length octet: zero ends the walk here
						if (b != 8'h00) eep_d = EW'(d) + EW'({b, 2'b00}) - EW'(1);
						else begin
							phase_d  = PH_INNER;
							go_inner = 1'b1;
						end
					end else begin
						if ({1'b0, d} == {1'b0, iso_q} + AW'(2) && pet_q == PSC_TYPE)
							qfi_d = b[5:0] & QFI_MASK;
						if (EW'(d) == eep_q) begin
							pet_d    = b;
							walked_d = walked_q + XW'(1);
							iso_d    = d + PW'(1);
							if (b == 8'h00 || walked_d >= EXT_LIMIT) phase_d = PH_INNER;
						end
					end
				end
				PH_INNER: go_inner = 1'b1;
				default: ;
			endcase
		end

		if (go_inner && d >= iso_q) begin
			if (k == '0) ver_d = b[7:4];
			case (k)
				PW'(2):  len_d[15:8]  = b;
				PW'(3):  len_d[7:0]   = b;
				PW'(12): src_d[31:24] = b;
				PW'(13): src_d[23:16] = b;
				PW'(14): src_d[15:8]  = b;
				PW'(15): src_d[7:0]   = b;
				PW'(16): dst_d[31:24] = b;
				PW'(17): dst_d[23:16] = b;
				PW'(18): dst_d[15:8]  = b;
				PW'(19): begin
					dst_d[7:0] = b;
					phase_d    = PH_DONE;
				end
				default: ;
			endcase
		end

		// result as seen after this item
		g_end = AW'(POS_IP_START + UDP_HDR_BYTES) + AW'({ohw_d, 2'b00});
		result = '0;
		if (rej_d || pos_d < PW'(MIN_FRAME) || {1'b0, pos_d} < g_end)
			result.parse_status = ST_NOT_GTPU;
		else if (phase_d == PH_OUTER || phase_d == PH_BASE || phase_d == PH_OPT
				|| phase_d == PH_EXT)
			result.parse_status = ST_GTP_TRUNC;
		else if (phase_d == PH_INNER)
			result.parse_status = ST_INNER_TRUNC;
		else if (ver_d == IP_VERSION_4)
			result.parse_status = ST_OK;
		else
			result.parse_status = ST_INNER_NOT_V4;

		if (result.parse_status != ST_NOT_GTPU && result.parse_status != ST_GTP_TRUNC) begin
			result.tunnel_id   = tid_d;
			result.flow_qos_id = qfi_d;
		end
		if (result.parse_status == ST_OK) begin
			result.inner_source       = src_d;
			result.inner_destination  = dst_d;
			result.inner_total_length = len_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_OUTER;
			pos_q    <= '0;
			ohw_q    <= '0;
			flags_q  <= '0;
			tid_q    <= '0;
			pet_q    <= '0;
			walked_q <= '0;
			eep_q    <= '0;
			iso_q    <= '0;
			qfi_q    <= '0;
			len_q    <= '0;
			src_q    <= '0;
			dst_q    <= '0;
			rej_q    <= 1'b0;
			ver_q    <= '0;
		end else if (step) begin
			if (item.last_byte) begin
				// frame done: start the next one clean
				phase_q  <= PH_OUTER;
				pos_q    <= '0;
				ohw_q    <= '0;
				flags_q  <= '0;
				tid_q    <= '0;
				pet_q    <= '0;
				walked_q <= '0;
				eep_q    <= '0;
				iso_q    <= '0;
				qfi_q    <= '0;
				len_q    <= '0;
				src_q    <= '0;
				dst_q    <= '0;
				rej_q    <= 1'b0;
				ver_q    <= '0;
			end else begin
				phase_q  <= phase_d;
				pos_q    <= pos_d;
				ohw_q    <= ohw_d;
				flags_q  <= flags_d;
				tid_q    <= tid_d;
				pet_q    <= pet_d;
				walked_q <= walked_d;
				eep_q    <= eep_d;
				iso_q    <= iso_d;
				qfi_q    <= qfi_d;
				len_q    <= len_d;
				src_q    <= src_d;
				dst_q    <= dst_d;
				rej_q    <= rej_d;
				ver_q    <= ver_d;
			end
		end
	end

endmodule

>>> rtl/core/gtpu_tunnel_header_parser.sv
// top level of the gtp-u tunnel header parser: input register, port register, result register
// depends on gtpu_hp_pkg, gtpu_hp_parser and gtpu_tunnel_header_parser_assert.svh
//
//  channel   handshake                   payload
//  frame     frame_valid / frame_stall   frame_data   (one byte, last mark)
//  result    result_valid / result_stall result_data  (one per frame)
//  config    cfg_wr_en                   cfg_wr_data  (gtp-u udp port)
//
// one byte per cycle sustained while frame_stall is low; every byte is parsed combinationally out of the input register
// a result is registered once its last byte leaves the input register, later only behind a held result
// reset clears all frame state and sets the port to 2152
// frame_stall rises only while a last byte waits behind a result not yet taken
module gtpu_tunnel_header_parser import gtpu_hp_pkg::*; #(
	parameter int MAX_EXT_HEADERS = 4,
	parameter int MAX_FRAME_BYTES = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        frame_valid,
	output logic        frame_stall,
	input  in_item_t    frame_data,
	output logic        result_valid,
	input  logic        result_stall,
	output out_item_t   result_data,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);

	`include "gtpu_tunnel_header_parser_assert.svh"

	in_item_t    item_s1;
	logic        valid_s1;
	logic [15:0] port_q;
	out_item_t   result_q;
	logic        res_valid_q;
	out_item_t   parsed;
	logic        advance;

	// a last byte needs a free result slot, other bytes always move on
	assign advance = valid_s1 && (!item_s1.last_byte || !res_valid_q || !result_stall);
	assign frame_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_valid && !frame_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_valid && !frame_stall) item_s1 <= frame_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_q <= PORT_AT_RESET;
		end else if (cfg_wr_en) begin
			port_q <= cfg_wr_data;
		end
	end

	gtpu_hp_parser #(
		.MAX_EXT_HEADERS(MAX_EXT_HEADERS),
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.item     (item_s1),
		.udp_port (port_q),
		.result   (parsed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && item_s1.last_byte) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_byte) result_q <= parsed;
	end

	assign result_valid = res_valid_q;
	assign result_data  = result_q;

	`GTPU_ASSERT_IMP(a_stall_only_when_full, frame_stall,
		valid_s1 && item_s1.last_byte && res_valid_q && result_stall,
		"input stalled without a blocked result")
	`GTPU_ASSERT_NXT(a_last_gives_result,
		valid_s1 && item_s1.last_byte && !frame_stall, res_valid_q,
		"last byte moved on without a result")
	`GTPU_ASSERT_IMP(a_inner_only_when_ok,
		res_valid_q && result_q.parse_status != ST_OK,
		result_q.inner_source == 32'd0 && result_q.inner_destination == 32'd0
			&& result_q.inner_total_length == 16'd0,
		"inner fields set on a result that is not ok")
	`GTPU_ASSERT_IMP(a_teid_only_when_parsed,
		res_valid_q && (result_q.parse_status == ST_NOT_GTPU
			|| result_q.parse_status == ST_GTP_TRUNC),
		result_q.tunnel_id == 32'd0 && result_q.flow_qos_id == 6'd0,
		"teid or qfi set without a full gtp-u header")

endmodule
